@@ rtl/mcc_pkg.sv @@
`timescale 1ns / 1ps

package mcc_pkg;

    // Longest suffix the delay line can hold behind the checksum field.
    localparam int MAX_SUFFIX  = 15;
    // Delay line depth: the suffix plus a two-byte CRC field.
    localparam int LINE_DEPTH  = MAX_SUFFIX + 2;
    localparam int LINE_IDX_W  = $clog2(LINE_DEPTH);

    localparam int BYTE_W      = 8;
    localparam int SUM_W       = 16;
    localparam int COUNT_W     = 16;
    localparam int LEN_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_DATA_W  = 40;

    localparam logic [SUM_W-1:0]   CRC_INIT  = 16'hFFFF;
    localparam logic [SUM_W-1:0]   CRC_POLY  = 16'hA001;
    localparam logic [SUM_W-1:0]   CRC_LSB   = 16'h0001;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Checksum kinds, as written to the method register.
    localparam logic METHOD_LRC = 1'b0;
    localparam logic METHOD_CRC = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_METHOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUFFIX = 2'd2;

    // Control from the checksum datapath to the delay line.
    typedef struct packed {
        logic                  shift;
        logic [BYTE_W-1:0]     data;
        logic [LINE_IDX_W-1:0] tap;
        logic [LEN_W-1:0]      sfx;
    } t_line_ctl;

    // Taps returned by the delay line.
    typedef struct packed {
        logic [BYTE_W-1:0] tap_byte;
        logic [BYTE_W-1:0] recv_hi;
        logic [BYTE_W-1:0] recv_lo;
    } t_line_taps;

    // Reflected CRC-16 update by one byte, unrolled over its eight bits.
    function automatic logic [SUM_W-1:0] crc16_byte(input logic [SUM_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [SUM_W-1:0] c;
        c = crc ^ {{(SUM_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            if ((c & CRC_LSB) != '0) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/mcc_delay_line.sv @@
`timescale 1ns / 1ps

module mcc_delay_line (
    input  logic                 i_clk,
    input  mcc_pkg::t_line_ctl   i_ctl,
    output mcc_pkg::t_line_taps  o_taps
);

    // Newest byte in entry 0. Every entry that is read has been written since
    // the message began, so the line needs no reset or clearing.
    logic [mcc_pkg::BYTE_W-1:0] r_line [mcc_pkg::LINE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_line[0] <= i_ctl.data;
            for (int k = 1; k < mcc_pkg::LINE_DEPTH; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    logic [mcc_pkg::LINE_IDX_W-1:0] sfx_idx;

    always_comb begin
        sfx_idx         = mcc_pkg::LINE_IDX_W'(i_ctl.sfx);
        o_taps.tap_byte = r_line[i_ctl.tap];
        // The received field as it sits after this word's shift.
        o_taps.recv_hi  = r_line[sfx_idx];
        if (i_ctl.sfx == '0) begin
            o_taps.recv_lo = i_ctl.data;
        end else begin
            o_taps.recv_lo = r_line[sfx_idx - mcc_pkg::LINE_IDX_W'(1)];
        end
    end

endmodule

@@ rtl/message_checksum_check_unit.sv @@
`timescale 1ns / 1ps
// Path: a final input word passes the input register, then lands in the result
// register; a stalled result can hold it in the input register.
// Throughput: one input word per cycle, set by the combinational CRC byte update
// and the delay-line shift. Only a stalled result slows the input.
// Reset (synchronous, active low) sets method to CRC-16, prefix and suffix to
// zero, and empties the pipeline and the message state.

module message_checksum_check_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream.
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,   // [7:0] data_byte
    input  logic                              i_s_tlast,   // last_byte
    // Result stream.
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [15:0] computed_sum, [31:16] received_sum, [32] sums_match,
    // [33] too_short, [39:34] zero
    output logic [mcc_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [mcc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mcc_pkg::LEN_W-1:0]         i_cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic                       r_method;
    logic [mcc_pkg::LEN_W-1:0]  r_prefix;
    logic [mcc_pkg::LEN_W-1:0]  r_suffix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method <= mcc_pkg::METHOD_CRC;
            r_prefix <= '0;
            r_suffix <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mcc_pkg::CFG_METHOD: r_method <= i_cfg_wdata[0];
                mcc_pkg::CFG_PREFIX: r_prefix <= i_cfg_wdata;
                mcc_pkg::CFG_SUFFIX: r_suffix <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register. A word that is not final never produces a result, so
    // it always moves on; a final word waits only for a free result slot.
    // ------------------------------------------------------------------
    logic                       r_in_valid;
    logic [mcc_pkg::BYTE_W-1:0] r_in_data;
    logic                       r_in_last;
    logic                       r_out_valid;
    logic                       advance;
    logic                       fire;

    assign advance    = !r_in_last || !r_out_valid || i_m_tready;
    assign fire       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_in_data <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Message state: both accumulators always run; the method in force at
    // the final word picks which one is reported.
    // ------------------------------------------------------------------
    logic [mcc_pkg::SUM_W-1:0]   r_crc;
    logic [mcc_pkg::BYTE_W-1:0]  r_lrc;
    logic [mcc_pkg::COUNT_W-1:0] r_count;
    logic [mcc_pkg::SUM_W-1:0]   n_crc;
    logic [mcc_pkg::BYTE_W-1:0]  n_lrc;
    logic [mcc_pkg::COUNT_W-1:0] n_count;

    logic [mcc_pkg::LEN_W-1:0]      sfx;
    logic [mcc_pkg::LINE_IDX_W-1:0] delay;
    logic [mcc_pkg::COUNT_W:0]      past_delay;
    logic                           do_absorb;
    logic [mcc_pkg::COUNT_W-1:0]    total;
    logic [mcc_pkg::LINE_IDX_W:0]   min_len;
    logic                           short_msg;

    mcc_pkg::t_line_ctl  line_ctl;
    mcc_pkg::t_line_taps line_taps;

    mcc_delay_line u_line (
        .i_clk  (i_clk),
        .i_ctl  (line_ctl),
        .o_taps (line_taps)
    );

    always_comb begin
        // Suffix saturates at the line's capacity.
        if (32'(r_suffix) > 32'(mcc_pkg::MAX_SUFFIX)) begin
            sfx = mcc_pkg::LEN_W'(mcc_pkg::MAX_SUFFIX);
        end else begin
            sfx = r_suffix;
        end
        // Delay covers the suffix plus the one- or two-byte checksum field.
        delay = mcc_pkg::LINE_IDX_W'(sfx) +
                ((r_method == mcc_pkg::METHOD_CRC) ? mcc_pkg::LINE_IDX_W'(2)
                                                   : mcc_pkg::LINE_IDX_W'(1));

        line_ctl.shift = fire;
        line_ctl.data  = r_in_data;
        line_ctl.tap   = delay - mcc_pkg::LINE_IDX_W'(1);
        line_ctl.sfx   = sfx;

        // The byte leaving the delay line is covered once it is past the prefix.
        past_delay = {1'b0, r_count} - (mcc_pkg::COUNT_W+1)'(delay);
        do_absorb  = !past_delay[mcc_pkg::COUNT_W] &&
                     (past_delay[mcc_pkg::COUNT_W-1:0] >=
                      mcc_pkg::COUNT_W'(r_prefix));

        if (do_absorb) begin
            n_crc = mcc_pkg::crc16_byte(r_crc, line_taps.tap_byte);
            n_lrc = r_lrc + line_taps.tap_byte;
        end else begin
            n_crc = r_crc;
            n_lrc = r_lrc;
        end

        if (r_count != mcc_pkg::COUNT_MAX) begin
            total = r_count + mcc_pkg::COUNT_W'(1);
        end else begin
            total = r_count;
        end

        min_len   = (mcc_pkg::LINE_IDX_W+1)'(r_prefix) +
                    (mcc_pkg::LINE_IDX_W+1)'(delay);
        short_msg = total < mcc_pkg::COUNT_W'(min_len);

        // A final word starts the next message from the reset values.
        if (r_in_last) begin
            n_count = '0;
        end else begin
            n_count = total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= mcc_pkg::CRC_INIT;
            r_lrc   <= '0;
            r_count <= '0;
        end else if (fire) begin
            r_crc   <= r_in_last ? mcc_pkg::CRC_INIT : n_crc;
            r_lrc   <= r_in_last ? '0 : n_lrc;
            r_count <= n_count;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic [mcc_pkg::SUM_W-1:0] comp_sum;
    logic [mcc_pkg::SUM_W-1:0] recv_sum;
    logic [mcc_pkg::SUM_W-1:0] r_comp;
    logic [mcc_pkg::SUM_W-1:0] r_recv;
    logic                      r_match;
    logic                      r_short;

    always_comb begin
        if (r_method == mcc_pkg::METHOD_CRC) begin
            // The CRC goes out byte-swapped; the field arrives high byte first.
            comp_sum = {n_crc[7:0], n_crc[15:8]};
            recv_sum = {line_taps.recv_hi, line_taps.recv_lo};
        end else begin
            comp_sum = {8'h00, 8'h00 - n_lrc};
            recv_sum = {8'h00, line_taps.recv_lo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_in_last) begin
            if (short_msg) begin
                r_comp  <= '0;
                r_recv  <= '0;
                r_match <= 1'b0;
                r_short <= 1'b1;
            end else begin
                r_comp  <= comp_sum;
                r_recv  <= recv_sum;
                r_match <= comp_sum == recv_sum;
                r_short <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_short, r_match, r_recv, r_comp};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_short |-> r_comp == '0 && r_recv == '0 && !r_match)
        else $error("too-short result carries nonzero sums");

    a_match_eq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_short |-> r_match == (r_comp == r_recv))
        else $error("match flag disagrees with the sums");

    a_msg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in_last |=> r_count == '0 && r_crc == mcc_pkg::CRC_INIT
                              && r_lrc == '0)
        else $error("message state not restarted after a final word");

    a_result_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready && r_in_valid && r_in_last |-> !fire)
        else $error("final word advanced into an occupied result slot");

endmodule

@@ dv/tb_message_checksum_check_unit.sv @@
`timescale 1ns / 1ps

module tb_message_checksum_check_unit;

    // A final byte passes the input register, then fills the result register.
    localparam int LATENCY      = 2;
    // Cycles without any accepted word or register write before the run is
    // declared hung.
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_WORDS = 1410;
    localparam int MAX_PRINTED  = 100;

    // Method register values as they travel on the 4-bit write data.
    localparam logic [mcc_pkg::LEN_W-1:0] WR_LRC =
        {{(mcc_pkg::LEN_W-1){1'b0}}, mcc_pkg::METHOD_LRC};
    localparam logic [mcc_pkg::LEN_W-1:0] WR_CRC =
        {{(mcc_pkg::LEN_W-1){1'b0}}, mcc_pkg::METHOD_CRC};

    // One check report, the content of a result word.
    typedef struct packed {
        logic [mcc_pkg::SUM_W-1:0] computed;
        logic [mcc_pkg::SUM_W-1:0] received;
        logic                      sums_match;
        logic                      too_short;
    } t_verdict;

    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_kind;

    // A row of the directed table: either a register write or one input byte.
    // Rows with known set carry a report typed in by hand; the others are
    // checked against the predictor.
    typedef struct packed {
        t_row_kind                     kind;
        logic [mcc_pkg::CFG_IDX_W-1:0] idx;
        logic [mcc_pkg::LEN_W-1:0]     val;
        logic [mcc_pkg::BYTE_W-1:0]    data;
        logic                          last;
        logic                          known;
        t_verdict                      want;
    } t_row;

    // Every input of the block has a known value from time zero.
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_s_tvalid  = 1'b0;
    logic [7:0]                     i_s_tdata   = '0;
    logic                           i_s_tlast   = 1'b0;
    logic                           i_m_tready  = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [mcc_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [mcc_pkg::LEN_W-1:0]      i_cfg_wdata = '0;
    logic                           o_s_tready;
    logic                           o_m_tvalid;
    logic [mcc_pkg::OUT_DATA_W-1:0] o_m_tdata;

    message_checksum_check_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),     // [7:0] data_byte
        .i_s_tlast   (i_s_tlast),     // last_byte
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        // [15:0] computed_sum, [31:16] received_sum, [32] sums_match,
        // [33] too_short
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the registers and of the per-message state.
    logic                        cfg_method;
    logic [mcc_pkg::LEN_W-1:0]   cfg_prefix;
    logic [mcc_pkg::LEN_W-1:0]   cfg_suffix;
    logic [mcc_pkg::SUM_W-1:0]   crc_acc;
    logic [mcc_pkg::BYTE_W-1:0]  lrc_acc;
    logic [mcc_pkg::COUNT_W-1:0] msg_count;
    logic [mcc_pkg::BYTE_W-1:0]  tail [mcc_pkg::LINE_DEPTH];

    t_verdict pending_verdicts [$];
    t_row     dir_rows [29];
    int       mismatch_count = 0;
    int       rand_words     = 0;
    int       idle_cycles    = 0;
    bit       sender_burst   = 1'b0;
    bit       sink_burst     = 1'b0;

    // Reflected CRC-16 step over one byte, bit by bit.
    function automatic logic [mcc_pkg::SUM_W-1:0] crc16_next(
            input logic [mcc_pkg::SUM_W-1:0] crc,
            input logic [mcc_pkg::BYTE_W-1:0] b);
        logic [mcc_pkg::SUM_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < mcc_pkg::BYTE_W; i++) begin
            c = c[0] ? ((c >> 1) ^ mcc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic t_row cfg_row(input logic [mcc_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [mcc_pkg::LEN_W-1:0] val);
        t_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    function automatic t_row byte_row(input logic [7:0] data, input logic last);
        t_row r;
        r = '0;
        r.kind = ROW_BYTE;
        r.data = data;
        r.last = last;
        return r;
    endfunction

    function automatic t_row known_row(input logic [7:0] data, input logic last,
                                       input t_verdict want);
        t_row r;
        r = byte_row(data, last);
        r.known = 1'b1;
        r.want  = want;
        return r;
    endfunction

    task automatic clear_message();
        crc_acc   = mcc_pkg::CRC_INIT;
        lrc_acc   = '0;
        msg_count = '0;
        foreach (tail[k]) tail[k] = '0;
    endtask

    // Advances the shadow state by one accepted byte. The checksum takes the
    // byte that falls out of the delay line, once the prefix has gone by; on
    // the final byte the report is formed and the message state cleared.
    task automatic predict_verdict(input logic [7:0] b, input logic last,
                                   output bit has_verdict, output t_verdict v);
        int sfx;
        int delay;
        sfx   = (int'(cfg_suffix) > mcc_pkg::MAX_SUFFIX) ? mcc_pkg::MAX_SUFFIX
                                                         : int'(cfg_suffix);
        delay = sfx + ((cfg_method == mcc_pkg::METHOD_CRC) ? 2 : 1);
        v = '0;
        has_verdict = last;
        if (int'(msg_count) >= delay && int'(msg_count) - delay >= int'(cfg_prefix)) begin
            crc_acc = crc16_next(crc_acc, tail[delay-1]);
            lrc_acc = lrc_acc + tail[delay-1];
        end
        for (int k = mcc_pkg::LINE_DEPTH - 1; k > 0; k--) tail[k] = tail[k-1];
        tail[0] = b;
        if (msg_count != mcc_pkg::COUNT_MAX) msg_count = msg_count + 1'b1;
        if (last) begin
            if (int'(msg_count) < int'(cfg_prefix) + delay) begin
                // Message too short to hold prefix, checksum and suffix.
                v.too_short = 1'b1;
            end else begin
                if (cfg_method == mcc_pkg::METHOD_CRC) begin
                    v.computed = {crc_acc[7:0], crc_acc[15:8]};
                    v.received = {tail[sfx+1], tail[sfx]};
                end else begin
                    v.computed = {8'h00, 8'h00 - lrc_acc};
                    v.received = {8'h00, tail[sfx]};
                end
                v.sums_match = (v.computed == v.received);
            end
            clear_message();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatch_count < MAX_PRINTED) begin
            $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    // Registers change only while nothing is in flight: every expected report
    // has come out, then the pipeline gets time to drain non-final bytes.
    task automatic write_reg(input logic [mcc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mcc_pkg::LEN_W-1:0] val);
        i_s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            mcc_pkg::CFG_METHOD: cfg_method = val[0];
            mcc_pkg::CFG_PREFIX: cfg_prefix = val;
            mcc_pkg::CFG_SUFFIX: cfg_suffix = val;
            default: ;
        endcase
    endtask

    // Lengths lean on the extremes, zero and fifteen.
    function automatic logic [mcc_pkg::LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return mcc_pkg::LEN_W'($urandom_range(0, 15));
    endfunction

    task automatic random_reg_write();
        case ($urandom_range(0, 2))
            0: write_reg(mcc_pkg::CFG_METHOD,
                         {3'($urandom_range(0, 7)),
                          ($urandom_range(0, 1) != 0) ? mcc_pkg::METHOD_CRC
                                                      : mcc_pkg::METHOD_LRC});
            1: write_reg(mcc_pkg::CFG_PREFIX, pick_len());
            default: write_reg(mcc_pkg::CFG_SUFFIX, pick_len());
        endcase
    endtask

    // Presents one byte after a random gap and holds it until it is taken.
    // The valid stays high when the next byte follows with no gap.
    task automatic send_byte(input logic [7:0] b, input logic last, input logic known,
                             input t_verdict want);
        int       gap;
        bit       got;
        t_verdict v;
        gap = sender_burst ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_verdict(b, last, got, v);
        if (got) pending_verdicts.push_back(known ? want : v);
    endtask

    // Builds one message. Most are well formed for the current registers,
    // with a correct checksum most of the time; the rest are noise, at most
    // the minimum length or up to 40 bytes. At times a register changes midway.
    task automatic send_random_message();
        logic [7:0]  msg [$];
        logic [7:0]  b;
        logic [15:0] crc;
        logic [7:0]  lrc;
        int          csize;
        int          kind;
        int          len;
        int          split;
        csize = (cfg_method == mcc_pkg::METHOD_CRC) ? 2 : 1;
        kind  = $urandom_range(0, 9);
        if (kind == 0) begin
            len = $urandom_range(1, int'(cfg_prefix) + csize + int'(cfg_suffix));
            repeat (len) msg.push_back(8'($urandom));
        end else if (kind == 1) begin
            len = $urandom_range(1, 40);
            repeat (len) msg.push_back(8'($urandom));
        end else begin
            repeat (cfg_prefix) msg.push_back(8'($urandom));
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
            crc = mcc_pkg::CRC_INIT;
            lrc = '0;
            repeat (len) begin
                b   = 8'($urandom);
                crc = crc16_next(crc, b);
                lrc = lrc + b;
                msg.push_back(b);
            end
            lrc = 8'h00 - lrc;
            if ($urandom_range(0, 3) == 0) begin
                crc = crc ^ (16'h0001 << $urandom_range(0, 15));
                lrc = lrc ^ (8'h01 << $urandom_range(0, 7));
            end
            // The first checksum byte on the wire is the high byte of the report.
            if (csize == 2) begin
                msg.push_back(crc[7:0]);
                msg.push_back(crc[15:8]);
            end else begin
                msg.push_back(lrc);
            end
            repeat (cfg_suffix) msg.push_back(8'($urandom));
        end
        split = (msg.size() > 1 && $urandom_range(0, 24) == 0) ?
                $urandom_range(1, msg.size() - 1) : 0;
        foreach (msg[i]) begin
            if (split != 0 && i == split) random_reg_write();
            send_byte(msg[i], i == msg.size() - 1, 1'b0, '0);
            rand_words++;
        end
    endtask

    // Result side: a random stall before each word, with stretches of none.
    // Each word taken is compared field by field with the oldest expectation.
    initial begin : result_sink
        int       stall;
        t_verdict want;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 11) == 0) sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected result word", o_m_tdata[15:0], '0);
            end else begin
                want = pending_verdicts.pop_front();
                if (o_m_tdata[15:0] !== want.computed)
                    report_mismatch("computed_sum", o_m_tdata[15:0], want.computed);
                if (o_m_tdata[31:16] !== want.received)
                    report_mismatch("received_sum", o_m_tdata[31:16], want.received);
                if (o_m_tdata[32] !== want.sums_match)
                    report_mismatch("sums_match", 16'(o_m_tdata[32]), 16'(want.sums_match));
                if (o_m_tdata[33] !== want.too_short)
                    report_mismatch("too_short", 16'(o_m_tdata[33]), 16'(want.too_short));
            end
        end
    end

    // Watchdog: any accepted word or register write restarts the count.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("message_checksum_check_unit test failed");
        $finish;
    end

    initial begin : stimulus
        // Shadow registers start at their reset values: CRC-16, no prefix,
        // no suffix.
        cfg_method = mcc_pkg::METHOD_CRC;
        cfg_prefix = '0;
        cfg_suffix = '0;
        clear_message();

        dir_rows = '{
            // Reset settings. A lone byte cannot hold a two-byte CRC field.
            known_row(8'h00, 1'b1, '{16'h0000, 16'h0000, 1'b0, 1'b1}),
            // Nothing covered: the CRC stays at its initial value.
            byte_row(8'hFF, 1'b0),
            known_row(8'hFF, 1'b1, '{16'hFFFF, 16'hFFFF, 1'b1, 1'b0}),
            byte_row(8'h01, 1'b0),
            byte_row(8'h80, 1'b0),
            byte_row(8'h7F, 1'b0),
            byte_row(8'h55, 1'b1),
            // LRC over an empty region is zero.
            cfg_row(mcc_pkg::CFG_METHOD, WR_LRC),
            known_row(8'hFF, 1'b1, '{16'h0000, 16'h00FF, 1'b0, 1'b0}),
            known_row(8'h00, 1'b1, '{16'h0000, 16'h0000, 1'b1, 1'b0}),
            byte_row(8'h01, 1'b0),
            known_row(8'hFF, 1'b1, '{16'h00FF, 16'h00FF, 1'b1, 1'b0}),
            // Longest prefix and suffix: one byte is far too short.
            cfg_row(mcc_pkg::CFG_PREFIX, 4'd15),
            cfg_row(mcc_pkg::CFG_SUFFIX, 4'd15),
            known_row(8'hAA, 1'b1, '{16'h0000, 16'h0000, 1'b0, 1'b1}),
            // CRC with a two-byte prefix and a one-byte suffix.
            cfg_row(mcc_pkg::CFG_METHOD, WR_CRC),
            cfg_row(mcc_pkg::CFG_PREFIX, 4'd2),
            cfg_row(mcc_pkg::CFG_SUFFIX, 4'd1),
            byte_row(8'h5A, 1'b0),
            byte_row(8'hA5, 1'b0),
            byte_row(8'h00, 1'b0),
            byte_row(8'hFF, 1'b0),
            byte_row(8'h12, 1'b0),
            byte_row(8'h34, 1'b0),
            byte_row(8'h80, 1'b1),
            // LRC with a one-byte prefix: a single byte is too short.
            cfg_row(mcc_pkg::CFG_METHOD, WR_LRC),
            cfg_row(mcc_pkg::CFG_PREFIX, 4'd1),
            cfg_row(mcc_pkg::CFG_SUFFIX, 4'd0),
            known_row(8'h33, 1'b1, '{16'h0000, 16'h0000, 1'b0, 1'b1})
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                write_reg(dir_rows[r].idx, dir_rows[r].val);
            end else begin
                send_byte(dir_rows[r].data, dir_rows[r].last, dir_rows[r].known,
                          dir_rows[r].want);
            end
        end

        // Random messages, with register changes between them from time to time.
        while (rand_words < RANDOM_WORDS) begin
            if ($urandom_range(0, 5) == 0) sender_burst = !sender_burst;
            if ($urandom_range(0, 14) == 0) begin
                repeat ($urandom_range(1, 3)) random_reg_write();
            end
            send_random_message();
        end
        i_s_tvalid <= 1'b0;

        // Drain: every report must arrive, then a further wait catches strays.
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 6) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("message_checksum_check_unit test passed");
        end else begin
            $display("message_checksum_check_unit test failed");
        end
        $finish;
    end

endmodule
